// ----- design/frustum_cull_test_macros.svh -----
// ---------------------------------------------------------------------------
// frustum_cull_test_macros.svh
// Assertion macros shared by the frustum cull checker.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/fct_pkg.sv -----
// ---------------------------------------------------------------------------
// fct_pkg
// Types and constants of the frustum cull test block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned NORMAL_W  = 18;
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned EXTENT_W  = 31;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned PROD_W    = NORMAL_W + COORD_W;
    localparam int unsigned REACH_W   = NORMAL_W + EXTENT_W;
    localparam int unsigned SUM_W     = 54;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                      opcode;
        logic        [SLOT_W-1:0]     slot;
        logic signed [NORMAL_W-1:0]   normal_x;
        logic signed [NORMAL_W-1:0]   normal_y;
        logic signed [NORMAL_W-1:0]   normal_z;
        logic signed [COORD_W-1:0]    plane_offset;
        logic signed [COORD_W-1:0]    center_x;
        logic signed [COORD_W-1:0]    center_y;
        logic signed [COORD_W-1:0]    center_z;
        logic        [EXTENT_W-1:0]   radius;
        logic        [EXTENT_W-1:0]   half_x;
        logic        [EXTENT_W-1:0]   half_y;
        logic        [EXTENT_W-1:0]   half_z;
        logic                         vis;
    } item_t;

endpackage

`default_nettype wire

// ----- design/fct_cell.sv -----
// ---------------------------------------------------------------------------
// fct_cell
// One plane of the culling chain: holds the plane, captures its load and
// folds its test into the visibility flag of each passing query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire fct_pkg::item_t in_item,
    output logic                in_ready,
    output logic                out_valid,
    output fct_pkg::item_t      out_item,
    input  wire logic           out_ready
);

    logic signed [fct_pkg::NORMAL_W-1:0] nx_reg;
    logic signed [fct_pkg::NORMAL_W-1:0] ny_reg;
    logic signed [fct_pkg::NORMAL_W-1:0] nz_reg;
    logic signed [fct_pkg::COORD_W-1:0]  d_reg;

    logic                                s1_valid_reg;
    fct_pkg::item_t                      s1_item_reg;
    logic signed [fct_pkg::PROD_W-1:0]   px_reg;
    logic signed [fct_pkg::PROD_W-1:0]   py_reg;
    logic signed [fct_pkg::PROD_W-1:0]   pz_reg;
    logic        [fct_pkg::REACH_W-1:0]  qx_reg;
    logic        [fct_pkg::REACH_W-1:0]  qy_reg;
    logic        [fct_pkg::REACH_W-1:0]  qz_reg;
    logic signed [fct_pkg::COORD_W-1:0]  pd_reg;

    logic                                s2_valid_reg;
    fct_pkg::item_t                      s2_item_reg;
    logic signed [fct_pkg::SUM_W-1:0]    dot_reg;
    logic signed [fct_pkg::SUM_W-1:0]    bias_reg;

    logic                                s3_valid_reg;
    fct_pkg::item_t                      s3_item_reg;
    fct_pkg::item_t                      s3_item_next;

    logic adv1;
    logic adv2;
    logic adv3;
    logic load_hit;

    logic        [fct_pkg::NORMAL_W-1:0] ax;
    logic        [fct_pkg::NORMAL_W-1:0] ay;
    logic        [fct_pkg::NORMAL_W-1:0] az;
    logic signed [fct_pkg::PROD_W-1:0]   px_next;
    logic signed [fct_pkg::PROD_W-1:0]   py_next;
    logic signed [fct_pkg::PROD_W-1:0]   pz_next;
    logic        [fct_pkg::REACH_W-1:0]  qx_next;
    logic        [fct_pkg::REACH_W-1:0]  qy_next;
    logic        [fct_pkg::REACH_W-1:0]  qz_next;
    logic signed [fct_pkg::SUM_W-1:0]    d_wide;
    logic signed [fct_pkg::SUM_W-1:0]    dot_next;
    logic signed [fct_pkg::SUM_W-1:0]    bias_next;
    logic signed [fct_pkg::SUM_W-1:0]    total;
    logic                                is_query;
    logic                                vis_next;

    assign adv3     = !s3_valid_reg || out_ready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    assign load_hit = adv1 && in_valid && (in_item.opcode == fct_pkg::OP_LOAD)
                      && (in_item.slot == fct_pkg::SLOT_W'(CELL_INDEX));

    // magnitudes of the stored normal
    assign ax = nx_reg[fct_pkg::NORMAL_W-1] ? (~nx_reg + 1'b1) : nx_reg;
    assign ay = ny_reg[fct_pkg::NORMAL_W-1] ? (~ny_reg + 1'b1) : ny_reg;
    assign az = nz_reg[fct_pkg::NORMAL_W-1] ? (~nz_reg + 1'b1) : nz_reg;

    assign px_next = fct_pkg::PROD_W'(nx_reg) * fct_pkg::PROD_W'(in_item.center_x);
    assign py_next = fct_pkg::PROD_W'(ny_reg) * fct_pkg::PROD_W'(in_item.center_y);
    assign pz_next = fct_pkg::PROD_W'(nz_reg) * fct_pkg::PROD_W'(in_item.center_z);
    assign qx_next = fct_pkg::REACH_W'(ax) * fct_pkg::REACH_W'(in_item.half_x);
    assign qy_next = fct_pkg::REACH_W'(ay) * fct_pkg::REACH_W'(in_item.half_y);
    assign qz_next = fct_pkg::REACH_W'(az) * fct_pkg::REACH_W'(in_item.half_z);

    assign d_wide = {{(fct_pkg::SUM_W - fct_pkg::COORD_W - fct_pkg::FRAC_W){pd_reg[
                        fct_pkg::COORD_W-1]}}, pd_reg, {fct_pkg::FRAC_W{1'b0}}};

    assign dot_next = fct_pkg::SUM_W'(px_reg) + fct_pkg::SUM_W'(py_reg)
                    + fct_pkg::SUM_W'(pz_reg) + d_wide;

    always_comb
    begin
        if (s1_item_reg.opcode == fct_pkg::OP_BOX)
        begin
            bias_next = fct_pkg::SUM_W'(qx_reg) + fct_pkg::SUM_W'(qy_reg)
                      + fct_pkg::SUM_W'(qz_reg);
        end
        else
        begin
            bias_next = {{(fct_pkg::SUM_W - fct_pkg::EXTENT_W - fct_pkg::FRAC_W){1'b0}},
                         s1_item_reg.radius, {fct_pkg::FRAC_W{1'b0}}};
        end
    end

    assign total    = dot_reg + bias_reg;
    assign is_query = (s2_item_reg.opcode == fct_pkg::OP_SPHERE)
                   || (s2_item_reg.opcode == fct_pkg::OP_BOX);
    assign vis_next = s2_item_reg.vis && !(is_query && total[fct_pkg::SUM_W-1]);

    always_comb
    begin
        s3_item_next     = s2_item_reg;
        s3_item_next.vis = vis_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg       <= '0;
            ny_reg       <= '0;
            nz_reg       <= '0;
            d_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_hit)
            begin
                nx_reg <= in_item.normal_x;
                ny_reg <= in_item.normal_y;
                nz_reg <= in_item.normal_z;
                d_reg  <= in_item.plane_offset;
            end
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_item_reg <= in_item;
            px_reg      <= px_next;
            py_reg      <= py_next;
            pz_reg      <= pz_next;
            qx_reg      <= qx_next;
            qy_reg      <= qy_next;
            qz_reg      <= qz_next;
            pd_reg      <= d_reg;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
            dot_reg     <= dot_next;
            bias_reg    <= bias_next;
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

`default_nettype wire

// ----- design/frustum_cull_test.sv -----
// ---------------------------------------------------------------------------
// frustum_cull_test
// Six-plane view frustum culling of spheres and boxes.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_ready) carries load, sphere and box items;
// output channel (out_valid / out_ready) carries one visible bit per query.
// A load writes the next plane slot and returns nothing; opcode 3 is
// dropped at the input. Items travel a chain of PLANE_COUNT cells, one
// plane per cell, so a load reaches its cell behind earlier queries and
// ahead of later ones.
// Each cell spends a multiply, a sum and a compare stage on its plane,
// then the output register takes the result.
// Throughput: one item per cycle while the receiver does not stall.
// Reset clears all planes to zero (nothing is culled) and the load slot.
// When the receiver stalls, the result holds in the output register and the
// chain keeps filling its empty stages; in_ready drops once every stage up
// to the output is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test #(
    parameter int unsigned PLANE_COUNT = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [fct_pkg::OP_W-1:0]    opcode,
    input  wire logic signed [fct_pkg::NORMAL_W-1:0] normal_x,
    input  wire logic signed [fct_pkg::NORMAL_W-1:0] normal_y,
    input  wire logic signed [fct_pkg::NORMAL_W-1:0] normal_z,
    input  wire logic signed [fct_pkg::COORD_W-1:0] plane_offset,
    input  wire logic signed [fct_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [fct_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [fct_pkg::COORD_W-1:0] center_z,
    input  wire logic        [fct_pkg::EXTENT_W-1:0] radius,
    input  wire logic        [fct_pkg::EXTENT_W-1:0] half_x,
    input  wire logic        [fct_pkg::EXTENT_W-1:0] half_y,
    input  wire logic        [fct_pkg::EXTENT_W-1:0] half_z,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    visible
);

    logic [fct_pkg::SLOT_W-1:0] load_slot_reg;
    logic                       out_valid_reg;
    logic                       visible_reg;

    logic                       chain_valid [PLANE_COUNT+1];
    logic                       chain_ready [PLANE_COUNT+1];
    fct_pkg::item_t             chain_item  [PLANE_COUNT+1];

    logic                       accept;
    logic                       tail_is_load;
    logic                       out_adv;
    fct_pkg::opcode_t           op;

    assign op       = fct_pkg::opcode_t'(opcode);
    assign in_ready = chain_ready[0];
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        chain_item[0].opcode       = op;
        chain_item[0].slot         = load_slot_reg;
        chain_item[0].normal_x     = normal_x;
        chain_item[0].normal_y     = normal_y;
        chain_item[0].normal_z     = normal_z;
        chain_item[0].plane_offset = plane_offset;
        chain_item[0].center_x     = center_x;
        chain_item[0].center_y     = center_y;
        chain_item[0].center_z     = center_z;
        chain_item[0].radius       = radius;
        chain_item[0].half_x       = half_x;
        chain_item[0].half_y       = half_y;
        chain_item[0].half_z       = half_z;
        chain_item[0].vis          = 1'b1;
    end

    // drop unused opcodes at the input
    assign chain_valid[0] = in_valid && (op != fct_pkg::OP_NONE);

    for (genvar i = 0; i < PLANE_COUNT; i++)
    begin : g_cell
        fct_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    assign tail_is_load = chain_item[PLANE_COUNT].opcode == fct_pkg::OP_LOAD;
    assign out_adv      = !out_valid_reg || out_ready;
    assign chain_ready[PLANE_COUNT] = tail_is_load || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && (op == fct_pkg::OP_LOAD))
            begin
                if (load_slot_reg == fct_pkg::SLOT_W'(PLANE_COUNT - 1))
                begin
                    load_slot_reg <= '0;
                end
                else
                begin
                    load_slot_reg <= load_slot_reg + 1'b1;
                end
            end
            if (out_adv)
            begin
                out_valid_reg <= chain_valid[PLANE_COUNT] && !tail_is_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            visible_reg <= chain_item[PLANE_COUNT].vis;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule

`default_nettype wire

// ----- design/fct_checker.sv -----
// ---------------------------------------------------------------------------
// fct_checker
// Port-level checks on the frustum cull test block, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frustum_cull_test_macros.svh"

module fct_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire logic visible
);

    `FCT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(visible), "result dropped or changed while stalled")
    `FCT_ASSERT(a_backpressure, !in_ready |-> out_valid && !out_ready, "input stalled without a stalled result")
    `FCT_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> !out_valid, "result present out of reset")
    `FCT_ASSERT(a_ready_in_reset_exit, $rose(rst_n) |-> in_ready || !in_valid, "input blocked right after reset")

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible)
);

`default_nettype wire
